>>> sv/salct_pkg.sv
// ----------------------------------------------------------------------------
// salct_pkg
// Shared types and constants for the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package salct_pkg;

  localparam int MAX_SETS = 256;
  localparam int MAX_WAYS = 8;
  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int WAY_W    = $clog2(MAX_WAYS);
  localparam int RANK_W   = WAY_W;
  localparam int TAG_W    = 32;
  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;

  // tag row: one tag per way; state row: ranks above valid bits
  localparam int TAG_ROW_W = MAX_WAYS * TAG_W;
  localparam int ST_ROW_W  = MAX_WAYS * (RANK_W + 1);

  localparam int IN_DATA_W  = 2 * ADDR_W;
  localparam int OUT_DATA_W = ((2 + 2 * CNT_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAYS_IN_USE       = 2'd0,
    CFG_SET_INDEX_BITS    = 2'd1,
    CFG_BLOCK_OFFSET_BITS = 2'd2,
    CFG_UNUSED            = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  typedef logic [MAX_WAYS-1:0] way_vec_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [WAY_W-1:0]    way_t;
  typedef logic [SET_W-1:0]    set_t;

endpackage

>>> sv/set_assoc_lru_cache_tracker_top.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker_top
// Hit/miss tracker for a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one access per transaction (base address + offset).
//   m_* channel returns one result per access: hit, evicted flag and the
//   running miss and access totals including that access.
//   cfg_we/cfg_index/cfg_data write the geometry registers; write only while
//   no access is in flight.
// Timing:
//   An accepted access reads its set from the tag and state RAMs in the
//   accept cycle; the lookup state then compares and picks the way, and once the
//   output register is free writes the set back and loads it. No new access is
//   taken before that single read-modify-write pass through the RAMs ends. m_tvalid
//   rises at the edge that leaves the lookup state.
//   s_tready is high while no access is in lookup; a new access is taken
//   while a result still waits on m_*. If m_tready stays low, the next
//   lookup holds until the output register frees up.
// Reset:
//   rst clears the per-set written flags (all lines invalid, ranks zero), the
//   counters, m_tvalid and the state, and loads the geometry defaults; no clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker_top (
  input  logic                                clk,
  input  logic                                rst,
  // fields from bit 0: base_address[31:0], address_offset[31:0]
  input  logic [salct_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // fields from bit 0: hit, evicted, miss_total[31:0], access_total[31:0], pad
  output logic [salct_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [salct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salct_pkg::CFG_W-1:0]         cfg_data
);

  import salct_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0] ways_in_use, set_index_bits, block_offset_bits;

  logic [CNT_W-1:0] miss_cnt, access_cnt;
  logic             out_hit, out_evicted;
  logic [CNT_W-1:0] out_miss, out_access;

  logic [TAG_W-1:0] line_q;
  set_t             set_q;
  logic [MAX_SETS-1:0] row_written;

  // accept side
  logic             s_fire;
  logic [ADDR_W-1:0] addr_sum;
  logic [TAG_W-1:0] line_in;
  set_t             set_mask, set_in;

  // RAM ports
  logic [TAG_ROW_W-1:0] tag_rdata, tag_wdata;
  logic [ST_ROW_W-1:0]  st_rdata, st_wdata;
  logic                 wr_en;

  // lookup
  logic [CFG_W-1:0] ways_eff;
  way_vec_t         way_en, vld, vld_new;
  rank_t            rank [MAX_WAYS];
  rank_t            rank_new [MAX_WAYS];
  logic [TAG_W-1:0] tags [MAX_WAYS];
  logic             found_ok, empty_ok, victim_ok;
  way_t             found_idx, empty_idx, victim_idx, target;
  logic             look_hit, look_fill, look_evict;
  rank_t            target_rank;
  logic             proceed;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  assign addr_sum = s_tdata[ADDR_W-1:0] + s_tdata[2*ADDR_W-1:ADDR_W];
  assign line_in  = addr_sum >> block_offset_bits;
  assign set_mask = (set_index_bits >= CFG_W'(SET_W)) ? '1
                  : set_t'((1 << set_index_bits) - 1);
  assign set_in   = line_in[SET_W-1:0] & set_mask;

  salct_ram #(.WIDTH(TAG_ROW_W), .DEPTH(MAX_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (set_q),
    .wdata (tag_wdata),
    .re    (s_fire),
    .raddr (set_in),
    .rdata (tag_rdata)
  );

  salct_ram #(.WIDTH(ST_ROW_W), .DEPTH(MAX_SETS)) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (set_q),
    .wdata (st_wdata),
    .re    (s_fire),
    .raddr (set_in),
    .rdata (st_rdata)
  );

  assign proceed = (state == ST_LOOK) && (!m_tvalid || m_tready);
  assign wr_en   = proceed;

  assign ways_eff = (ways_in_use == '0) ? CFG_W'(1)
                  : (ways_in_use > CFG_W'(MAX_WAYS)) ? CFG_W'(MAX_WAYS) : ways_in_use;

  always_comb begin
    found_ok   = 1'b0;
    empty_ok   = 1'b0;
    victim_ok  = 1'b0;
    found_idx  = '0;
    empty_idx  = '0;
    victim_idx = '0;
    // a set never written since reset reads as all invalid, ranks zero
    vld = row_written[set_q] ? st_rdata[MAX_WAYS-1:0] : '0;
    for (int y = 0; y < MAX_WAYS; y++) begin
      rank[y]   = row_written[set_q] ? st_rdata[MAX_WAYS + y*RANK_W +: RANK_W] : '0;
      tags[y]   = tag_rdata[y*TAG_W +: TAG_W];
      way_en[y] = (CFG_W'(y) < ways_eff);
    end
    for (int y = 0; y < MAX_WAYS; y++) begin
      if (way_en[y]) begin
        if (vld[y]) begin
          if (!found_ok && tags[y] == line_q) begin
            found_ok  = 1'b1;
            found_idx = way_t'(y);
          end
          if (!victim_ok || rank[y] > rank[victim_idx]) begin
            victim_ok  = 1'b1;
            victim_idx = way_t'(y);
          end
        end else if (!empty_ok) begin
          empty_ok  = 1'b1;
          empty_idx = way_t'(y);
        end
      end
    end

    look_hit   = found_ok;
    look_fill  = !found_ok && empty_ok;
    look_evict = !found_ok && !empty_ok;
    target     = look_hit ? found_idx : (look_fill ? empty_idx : victim_idx);
    target_rank = rank[target];

    vld_new = vld;
    if (look_fill) begin
      vld_new[target] = 1'b1;
    end
    for (int y = 0; y < MAX_WAYS; y++) begin
      if (way_t'(y) == target) begin
        rank_new[y] = '0;
      end else if (vld[y] && (look_fill || rank[y] < target_rank)) begin
        rank_new[y] = rank[y] + rank_t'(1);
      end else begin
        rank_new[y] = rank[y];
      end
    end

    tag_wdata = tag_rdata;
    if (!look_hit) begin
      tag_wdata[target*TAG_W +: TAG_W] = line_q;
    end
    st_wdata[MAX_WAYS-1:0] = vld_new;
    for (int y = 0; y < MAX_WAYS; y++) begin
      st_wdata[MAX_WAYS + y*RANK_W +: RANK_W] = rank_new[y];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_fire)  state_next = ST_LOOK;
      ST_LOOK: if (proceed) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      ways_in_use       <= CFG_W'(1);
      set_index_bits    <= '0;
      block_offset_bits <= '0;
      miss_cnt          <= '0;
      access_cnt        <= '0;
      m_tvalid          <= 1'b0;
      row_written       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAYS_IN_USE:       ways_in_use       <= cfg_data;
          CFG_SET_INDEX_BITS:    set_index_bits    <= cfg_data;
          CFG_BLOCK_OFFSET_BITS: block_offset_bits <= cfg_data;
          default: ;
        endcase
      end
      if (proceed) begin
        row_written[set_q] <= 1'b1;
        access_cnt         <= access_cnt + CNT_W'(1);
        if (!look_hit) begin
          miss_cnt <= miss_cnt + CNT_W'(1);
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      line_q <= line_in;
      set_q  <= set_in;
    end
    if (proceed) begin
      out_hit     <= look_hit;
      out_evicted <= look_evict;
      out_miss    <= look_hit ? miss_cnt : miss_cnt + CNT_W'(1);
      out_access  <= access_cnt + CNT_W'(1);
    end
  end

  assign m_tdata = {(OUT_DATA_W - 2 - 2*CNT_W)'(0), out_access, out_miss, out_evicted, out_hit};

endmodule

>>> sv/salct_ram.sv
// ----------------------------------------------------------------------------
// salct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module salct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache tracker. A shadow
// cache (tags, valid bits, recency ranks, counters) predicts hit, eviction and
// running totals for every accepted access; results are checked in order.
// Directed accesses cover fills, LRU eviction, address wrap, associativity
// limits, stale and duplicate lines and set aliasing, followed by random
// traffic over many geometries with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import salct_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] misses;
    logic [31:0] accesses;
  } access_result_t;

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  set_assoc_lru_cache_tracker_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow cache
  bit [31:0]   shadow_tag   [MAX_SETS][MAX_WAYS];
  bit          shadow_valid [MAX_SETS][MAX_WAYS];
  bit [7:0]    shadow_rank  [MAX_SETS][MAX_WAYS];
  logic [31:0] tracked_misses   = '0;
  logic [31:0] tracked_accesses = '0;
  logic [3:0]  shadow_ways        = 4'd1;
  logic [3:0]  shadow_set_bits    = 4'd0;
  logic [3:0]  shadow_offset_bits = 4'd0;

  // expected results in flight, kept as a ring with free-running counters
  access_result_t outcome_fifo [64];
  int             fifo_wr = 0;
  int             fifo_rd = 0;
  access_result_t seen_outcome;
  access_result_t want_outcome;
  int             mismatch_count = 0;

  int burst_left  = 0;
  int hold_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // shadow model
  // ------------------------------------------------------------------
  function automatic void promote_way(input int unsigned set_no, input int way);
    bit [7:0] r;
    r = shadow_rank[set_no][way];
    for (int y = 0; y < MAX_WAYS; y++) begin
      if (y != way && shadow_valid[set_no][y] && shadow_rank[set_no][y] < r)
        shadow_rank[set_no][y] = shadow_rank[set_no][y] + 8'd1;
    end
    shadow_rank[set_no][way] = '0;
  endfunction

  function automatic access_result_t cache_access_outcome(input logic [31:0] base,
                                                          input logic [31:0] ofs);
    logic [31:0]    addr;
    logic [31:0]    line;
    int unsigned    set_no;
    int             nways;
    int             hit_way;
    int             free_way;
    int             lru_way;
    access_result_t res;
    addr  = base + ofs;
    nways = (shadow_ways == 0) ? 1
          : (shadow_ways > MAX_WAYS) ? MAX_WAYS : int'(shadow_ways);
    line  = addr >> shadow_offset_bits;
    set_no = (line & ((32'd1 << shadow_set_bits) - 32'd1)) % MAX_SETS;
    hit_way  = -1;
    free_way = -1;
    lru_way  = -1;
    for (int y = 0; y < nways; y++) begin
      if (shadow_valid[set_no][y]) begin
        if (hit_way < 0 && shadow_tag[set_no][y] == line) hit_way = y;
        if (lru_way < 0 || shadow_rank[set_no][y] > shadow_rank[set_no][lru_way])
          lru_way = y;
      end else if (free_way < 0) begin
        free_way = y;
      end
    end
    tracked_accesses = tracked_accesses + 32'd1;
    res.hit     = 1'b0;
    res.evicted = 1'b0;
    if (hit_way >= 0) begin
      res.hit = 1'b1;
      promote_way(set_no, hit_way);
    end else begin
      tracked_misses = tracked_misses + 32'd1;
      if (free_way >= 0) begin
        // new line ages every other valid line, saturating
        for (int y = 0; y < MAX_WAYS; y++) begin
          if (y != free_way && shadow_valid[set_no][y] &&
              shadow_rank[set_no][y] < 8'd255)
            shadow_rank[set_no][y] = shadow_rank[set_no][y] + 8'd1;
        end
        shadow_rank[set_no][free_way]  = '0;
        shadow_valid[set_no][free_way] = 1'b1;
        shadow_tag[set_no][free_way]   = line;
      end else begin
        res.evicted = 1'b1;
        promote_way(set_no, lru_way);
        shadow_tag[set_no][lru_way] = line;
      end
    end
    res.misses   = tracked_misses;
    res.accesses = tracked_accesses;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // result checker
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_outcome.hit      = m_tdata[0];
      seen_outcome.evicted  = m_tdata[1];
      seen_outcome.misses   = m_tdata[33:2];
      seen_outcome.accesses = m_tdata[65:34];
      if (fifo_wr == fifo_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing pending: tdata=%h", $realtime, m_tdata);
      end else begin
        want_outcome = outcome_fifo[fifo_rd % 64];
        fifo_rd++;
        if (seen_outcome.hit !== want_outcome.hit ||
            seen_outcome.evicted !== want_outcome.evicted ||
            seen_outcome.misses !== want_outcome.misses ||
            seen_outcome.accesses !== want_outcome.accesses) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp hit=%0b evict=%0b miss=%0d acc=%0d %s",
                     $realtime, want_outcome.hit, want_outcome.evicted,
                     want_outcome.misses, want_outcome.accesses,
                     $sformatf("got hit=%0b evict=%0b miss=%0d acc=%0d",
                               seen_outcome.hit, seen_outcome.evicted,
                               seen_outcome.misses, seen_outcome.accesses));
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver: stall pattern, plus long hold-offs on request
  // ------------------------------------------------------------------
  initial begin
    logic [15:0] stall_pattern;
    int          stall_pos;
    stall_pattern = '1;
    stall_pos     = 0;
    m_tready      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else begin
        if (stall_pos == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = 16'($urandom);
            2: stall_pattern = 16'($urandom | $urandom);
            default: stall_pattern = 16'($urandom & $urandom);
          endcase
        end
        m_tready  = stall_pattern[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
      end
    end
  end

  // ------------------------------------------------------------------
  // driver tasks (called at a falling edge, return at a falling edge)
  // ------------------------------------------------------------------
  task automatic send_access(input logic [31:0] base, input logic [31:0] ofs);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(30, 80);
      end else begin
        gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {ofs, base};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    outcome_fifo[fifo_wr % 64] = cache_access_outcome(base, ofs);
    fifo_wr++;
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain_outcomes();
    while (fifo_wr != fifo_rd) @(negedge clk);
    // leave margin before touching registers
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [3:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      CFG_WAYS_IN_USE:       shadow_ways        = val;
      CFG_SET_INDEX_BITS:    shadow_set_bits    = val;
      CFG_BLOCK_OFFSET_BITS: shadow_offset_bits = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_config(input logic [3:0] ways, input logic [3:0] set_bits,
                              input logic [3:0] offset_bits);
    drain_outcomes();
    write_reg(CFG_WAYS_IN_USE, ways);
    write_reg(CFG_SET_INDEX_BITS, set_bits);
    write_reg(CFG_BLOCK_OFFSET_BITS, offset_bits);
  endtask

  // Working-set traffic: a pool of lines crowded into a few sets so that hits,
  // fills and evictions all occur, mixed with fully random addresses.
  task automatic run_traffic(input int n_items);
    logic [31:0] line_pool [20];
    int          pool_used;
    logic [31:0] addr;
    logic [31:0] line;
    logic [31:0] off_mask;
    logic [31:0] set_mask;
    logic [31:0] base;
    int          pool_cap;
    int          hot_sets;
    int          sel;
    pool_used = 0;
    off_mask = (32'd1 << shadow_offset_bits) - 32'd1;
    set_mask = (32'd1 << shadow_set_bits) - 32'd1;
    pool_cap = $urandom_range(1, 20);
    hot_sets = $urandom_range(1, 4);
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        addr = $urandom;
      end else if (sel < 25 || pool_used == 0) begin
        line = ($urandom & ~set_mask) | ($urandom_range(0, hot_sets - 1) & set_mask);
        addr = line << shadow_offset_bits;
        if (pool_used < pool_cap) begin
          line_pool[pool_used] = addr;
          pool_used++;
        end else begin
          line_pool[$urandom_range(0, pool_used - 1)] = addr;
        end
        addr = addr | ($urandom & off_mask);
      end else begin
        addr = line_pool[$urandom_range(0, pool_used - 1)] | ($urandom & off_mask);
      end
      base = $urandom;
      send_access(base, addr - base);
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_fill_and_evict();
    // two ways, two sets, 16-byte blocks; set 0 sees three lines
    apply_config(4'd2, 4'd1, 4'd4);
    send_access(32'h0000_0000, 32'h0000_0000);
    send_access(32'h0000_0004, 32'h0000_0008);
    send_access(32'h0000_0020, 32'h0000_0000);
    send_access(32'h0000_0040, 32'h0000_0000);
    send_access(32'h0000_0000, 32'h0000_0000);
    send_access(32'hFFFF_FFF0, 32'h0000_0050);   // wraps to 0x40
  endtask

  task automatic test_extreme_fields();
    apply_config(4'd1, 4'd0, 4'd0);
    send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(32'h0000_0000, 32'h0000_0000);
    send_access(32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_way_limits();
    // zero ways behaves as one
    apply_config(4'd0, 4'd0, 4'd0);
    send_access(32'h1000_0000, 32'h0000_0010);
    send_access(32'h2000_0000, 32'h0000_0010);
    // above the built ways behaves as the maximum; unused index is ignored
    apply_config(4'd15, 4'd0, 4'd0);
    write_reg(CFG_UNUSED, 4'hF);
    send_access(32'h3000_0000, 32'h0000_0010);
    send_access(32'h1000_0000, 32'h0000_0010);
  endtask

  task automatic test_duplicate_lines();
    // shrink ways so a line is refilled in way 0 while a copy sits in way 1
    apply_config(4'd2, 4'd0, 4'd0);
    send_access(32'h0000_0A00, 32'h0);
    send_access(32'h0000_0B00, 32'h0);
    drain_outcomes();
    write_reg(CFG_WAYS_IN_USE, 4'd1);
    send_access(32'h0000_0A00, 32'h0);
    send_access(32'h0000_0C00, 32'h0);
    send_access(32'h0000_0B00, 32'h0);
    drain_outcomes();
    write_reg(CFG_WAYS_IN_USE, 4'd2);
    send_access(32'h0000_0B00, 32'h0);
    send_access(32'h0000_0A00, 32'h0);
  endtask

  task automatic test_set_aliasing();
    // 12 index bits fold onto 256 sets; full line address keeps them apart
    apply_config(4'd1, 4'd12, 4'd0);
    send_access(32'h0000_0005, 32'h0);
    send_access(32'h0000_0105, 32'h0);
    send_access(32'h0000_0005, 32'h0);
    // larger blocks, no flush: line 5 now matches the stale byte-granular tag
    drain_outcomes();
    write_reg(CFG_BLOCK_OFFSET_BITS, 4'd4);
    send_access(32'h0000_0050, 32'h0);
  endtask

  task automatic test_backpressure();
    apply_config(4'd4, 4'd2, 4'd2);
    hold_cycles = 250;
    run_traffic(40);
  endtask

  task automatic test_random_traffic();
    logic [3:0] geo [10][3] = '{
      '{4'd1, 4'd0, 4'd0}, '{4'd8, 4'd8, 4'd12}, '{4'd4, 4'd2, 4'd4},
      '{4'd2, 4'd3, 4'd0}, '{4'd8, 4'd0, 4'd6}, '{4'd15, 4'd15, 4'd15},
      '{4'd0, 4'd5, 4'd3}, '{4'd3, 4'd1, 4'd2}, '{4'd6, 4'd4, 4'd1},
      '{4'd5, 4'd8, 4'd12}};
    for (int p = 0; p < 10; p++) begin
      apply_config(geo[p][0], geo[p][1], geo[p][2]);
      run_traffic(130);
    end
    for (int p = 0; p < 3; p++) begin
      apply_config(4'($urandom), 4'($urandom), 4'($urandom));
      run_traffic(130);
    end
  endtask

  initial begin
    int waited;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_WAYS_IN_USE;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_and_evict();
    test_extreme_fields();
    test_way_limits();
    test_duplicate_lines();
    test_set_aliasing();
    test_backpressure();
    test_random_traffic();

    waited = 0;
    while (fifo_wr != fifo_rd && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && fifo_wr == fifo_rd) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
